@@ rtl/core/cfa_pkg.sv @@
// cfa_pkg: shared types, character codes and helper functions for the
// can frame to ascii line encoder. No dependencies.

package cfa_pkg;

    localparam int DEF_MAX_DATA_BYTES = 64;
    localparam int LEN_W              = 7;
    localparam int ID_W               = 29;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CH_T_STD = 8'h74;  // 't'
    localparam logic [7:0] CH_T_EXT = 8'h54;  // 'T'
    localparam logic [7:0] CH_R_STD = 8'h72;  // 'r'
    localparam logic [7:0] CH_R_EXT = 8'h52;  // 'R'
    localparam logic [7:0] CH_F_STD = 8'h66;  // 'f'
    localparam logic [7:0] CH_F_EXT = 8'h46;  // 'F'
    localparam logic [7:0] CH_U_STD = 8'h75;  // 'u'
    localparam logic [7:0] CH_U_EXT = 8'h55;  // 'U'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic            is_fd;
        logic            is_remote;
        logic            is_extended;
        logic [ID_W-1:0] frame_identifier;
        logic [3:0]      length_code;
        logic [7:0]      data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       end_of_line;
        logic       last;
        logic       frame_dropped;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_DATA,
        CMD_DROP
    } cmd_kind_t;

    // one queued unit of work for the back end
    typedef struct packed {
        cmd_kind_t       kind;
        logic [7:0]      letter;
        logic            ext;
        logic [ID_W-1:0] ident;
        logic [7:0]      data;
        logic            eol;
    } cmd_t;

    function automatic logic [LEN_W-1:0] len_of(input logic [3:0] code);
        logic [LEN_W-1:0] n;
        case (code)
            4'd9:    n = 7'd12;
            4'd10:   n = 7'd16;
            4'd11:   n = 7'd20;
            4'd12:   n = 7'd24;
            4'd13:   n = 7'd32;
            4'd14:   n = 7'd48;
            4'd15:   n = 7'd64;
            default: n = {3'b000, code};
        endcase
        return n;
    endfunction

    function automatic logic [7:0] type_letter(input logic fd, input logic remote,
                                               input logic ext);
        logic [7:0] c;
        case ({fd, remote, ext})
            3'b000:  c = CH_T_STD;
            3'b001:  c = CH_T_EXT;
            3'b010:  c = CH_R_STD;
            3'b011:  c = CH_R_EXT;
            3'b100:  c = CH_F_STD;
            3'b101:  c = CH_F_EXT;
            3'b110:  c = CH_U_STD;
            default: c = CH_U_EXT;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'b0000, nib};
        else
            c = CH_A + {4'b0000, nib - 4'd10};
        return c;
    endfunction

endpackage

@@ rtl/core/cfa_front.sv @@
// cfa_front: accepts input beats, tracks the frame byte count and drop flag,
// and turns each beat into at most one command. Depends on cfa_pkg.

module cfa_front #(
    parameter int MAX_DATA_BYTES = cfa_pkg::DEF_MAX_DATA_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  cfa_pkg::in_item_t item,
    input  logic             q_full,
    output logic             push,
    output cfa_pkg::cmd_t    push_cmd
);

    localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);

    logic [CNT_W-1:0]         remaining_reg, remaining_next;
    logic                     discard_reg, discard_next;
    logic                     accept;
    logic [cfa_pkg::LEN_W-1:0] raw_count;
    logic [CNT_W-1:0]         count;
    logic                     id_too_big;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    always_comb
    begin
        raw_count  = cfa_pkg::len_of(item.length_code);
        count      = (raw_count > cfa_pkg::LEN_W'(MAX_DATA_BYTES)) ?
                     CNT_W'(MAX_DATA_BYTES) : raw_count[CNT_W-1:0];
        id_too_big = !item.is_extended && (item.frame_identifier[cfa_pkg::ID_W-1:12] != '0);

        remaining_next = remaining_reg;
        discard_next   = discard_reg;
        push           = 1'b0;

        push_cmd.kind   = cfa_pkg::CMD_HEADER;
        push_cmd.letter = cfa_pkg::type_letter(item.is_fd, item.is_remote, item.is_extended);
        push_cmd.ext    = item.is_extended;
        push_cmd.ident  = item.frame_identifier;
        push_cmd.data   = item.data_byte;
        push_cmd.eol    = (count == '0);

        if (accept)
        begin
            if (item.req_type == cfa_pkg::REQ_HEADER)
            begin
                remaining_next = count;
                discard_next   = id_too_big;
                push           = 1'b1;
                if (id_too_big)
                    push_cmd.kind = cfa_pkg::CMD_DROP;
            end
            else if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - CNT_W'(1);
                push           = !discard_reg;
                push_cmd.kind  = cfa_pkg::CMD_DATA;
                push_cmd.eol   = (remaining_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

@@ rtl/core/cfa_queue.sv @@
// cfa_queue: short command queue between front and back end.
// Depends on cfa_pkg.

module cfa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output cfa_pkg::cmd_t head
);

    localparam int PTR_W = $clog2(cfa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cfa_pkg::QUEUE_DEPTH + 1);

    cfa_pkg::cmd_t    slots_reg [cfa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(cfa_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(cfa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/core/cfa_back.sv @@
// cfa_back: steps through one queued command a character per cycle unless
// stalled, holding each character in the output register. Depends on cfa_pkg.

module cfa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cfa_pkg::cmd_t      head,
    output logic               pop,
    output logic               text_valid,
    input  logic               text_stall,
    output cfa_pkg::out_item_t text
);

    cfa_pkg::cmd_t      cmd_reg;
    logic               busy_reg, busy_next;
    logic [3:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    cfa_pkg::out_item_t out_reg;
    cfa_pkg::out_item_t cur;
    logic               advance, final_step, load;
    logic [3:0]         ndig;
    logic [2:0]         nib_idx;
    logic [31:0]        id32;

    assign text_valid = out_valid_reg;
    assign text       = out_reg;

    always_comb
    begin
        ndig    = cmd_reg.ext ? 4'd8 : 4'd3;
        nib_idx = 3'(ndig - step_reg);
        id32    = {3'b000, cmd_reg.ident};

        cur.ascii_char    = cfa_pkg::CH_NUL;
        cur.end_of_line   = 1'b0;
        cur.frame_dropped = 1'b0;
        final_step        = 1'b1;

        unique case (cmd_reg.kind)
            cfa_pkg::CMD_HEADER:
            begin
                if (step_reg == 4'd0)
                    cur.ascii_char = cmd_reg.letter;
                else if (step_reg <= ndig)
                    cur.ascii_char = cfa_pkg::hex_digit(id32[{nib_idx, 2'b00} +: 4]);
                else
                    cur.ascii_char = cfa_pkg::CH_CR;
                cur.end_of_line = (step_reg > ndig);
                final_step      = (step_reg == ndig + {3'b000, cmd_reg.eol});
            end
            cfa_pkg::CMD_DATA:
            begin
                if (step_reg == 4'd0)
                    cur.ascii_char = cfa_pkg::hex_digit(cmd_reg.data[7:4]);
                else if (step_reg == 4'd1)
                    cur.ascii_char = cfa_pkg::hex_digit(cmd_reg.data[3:0]);
                else
                    cur.ascii_char = cfa_pkg::CH_CR;
                cur.end_of_line = (step_reg == 4'd2);
                final_step      = (step_reg == (cmd_reg.eol ? 4'd2 : 4'd1));
            end
            cfa_pkg::CMD_DROP:
            begin
                cur.end_of_line   = 1'b1;
                cur.frame_dropped = 1'b1;
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
        cur.last = final_step;

        advance = busy_reg && (!out_valid_reg || !text_stall);
        load    = q_valid && (!busy_reg || (advance && final_step));
        pop     = load;

        busy_next = busy_reg;
        step_next = step_reg;
        if (load)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
        end
        else if (advance)
        begin
            busy_next = !final_step;
            step_next = step_reg + 4'd1;
        end

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !text_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= head;
        if (advance)
            out_reg <= cur;
    end

endmodule

@@ rtl/core/can_frame_to_ascii_line.sv @@
// can_frame_to_ascii_line: top level of the can frame to ascii line encoder.
// Depends on cfa_pkg, cfa_front, cfa_queue and cfa_back.

// Each header beat becomes one text line start: a type letter and 3 or 8 hex
// digits, plus a carriage return when the frame carries no bytes; each data
// beat becomes two hex digits, plus the carriage return on the frame's last
// byte. A standard identifier above 0xfff gives a single drop beat and the
// frame's bytes are swallowed. The front end takes an input beat every cycle
// while the two-entry command queue has room; the back end emits one character
// per cycle unless the output stalls, so a data byte gives 2 or 3 characters,
// a header 4 to 10 and a dropped header 1. Sustained throughput is set by the
// character serializer in the back end.

module can_frame_to_ascii_line #(
    parameter int MAX_DATA_BYTES = cfa_pkg::DEF_MAX_DATA_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cfa_pkg::in_item_t  item,
    output logic               text_valid,
    input  logic               text_stall,
    output cfa_pkg::out_item_t text
);

    logic          q_full;
    logic          push;
    cfa_pkg::cmd_t push_cmd;
    logic          pop;
    logic          q_valid;
    cfa_pkg::cmd_t head;

    cfa_front #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cfa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    cfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

endmodule

@@ bench/tb_can_frame_to_ascii_line.sv @@
`timescale 1ns / 100ps
// tb_can_frame_to_ascii_line: self-checking bench for the can frame to ascii line encoder.
// Predicts every text beat from the input beats and checks them in order.
// Depends on cfa_pkg and can_frame_to_ascii_line.

module tb_can_frame_to_ascii_line;

    localparam int MAX_BYTES   = cfa_pkg::DEF_MAX_DATA_BYTES;
    localparam int QUIET_LIMIT = 2000;
    localparam int FRAME_BYTES [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    cfa_pkg::in_item_t  item = '0;
    logic               text_valid;
    logic               text_stall = 1'b0;
    cfa_pkg::out_item_t text;

    cfa_pkg::out_item_t expected_text [$];
    int                 bytes_owed = 0;
    logic               frame_discarded = 1'b0;
    bit                 idling = 1'b0;
    int                 rx_wait = 0;
    int                 quiet_cycles = 0;
    int                 error_count = 0;

    can_frame_to_ascii_line #(
        .MAX_DATA_BYTES(MAX_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .text      (text)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int byte_count(input logic [3:0] code);
        int n;
        n = FRAME_BYTES[code];
        if (n > MAX_BYTES)
            n = MAX_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 | {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

    function automatic cfa_pkg::out_item_t text_beat(input logic [7:0] ch, input logic eol,
                                                     input logic drop);
        cfa_pkg::out_item_t r;
        r.ascii_char    = ch;
        r.end_of_line   = eol;
        r.last          = 1'b0;
        r.frame_dropped = drop;
        return r;
    endfunction

    // works out the characters one input beat produces and queues them
    task automatic encode_beat(input cfa_pkg::in_item_t b);
        cfa_pkg::out_item_t line [$];
        logic [31:0]        idw;
        logic [7:0]         letter;
        int                 ndig;
        if (b.req_type == cfa_pkg::REQ_HEADER)
        begin
            bytes_owed = byte_count(b.length_code);
            if (!b.is_extended && b.frame_identifier > 29'hFFF)
            begin
                frame_discarded = 1'b1;
                line = {line, text_beat(cfa_pkg::CH_NUL, 1'b1, 1'b1)};
            end
            else
            begin
                frame_discarded = 1'b0;
                case ({b.is_fd, b.is_remote})
                    2'b00:   letter = cfa_pkg::CH_T_STD;
                    2'b01:   letter = cfa_pkg::CH_R_STD;
                    2'b10:   letter = cfa_pkg::CH_F_STD;
                    default: letter = cfa_pkg::CH_U_STD;
                endcase
                // extended identifiers take the upper-case letter
                if (b.is_extended)
                    letter = letter & 8'hDF;
                line = {line, text_beat(letter, 1'b0, 1'b0)};
                idw  = {3'b000, b.frame_identifier};
                ndig = b.is_extended ? 8 : 3;
                for (int i = ndig - 1; i >= 0; i--)
                    line = {line, text_beat(hex_char(idw[4*i +: 4]), 1'b0, 1'b0)};
                if (bytes_owed == 0)
                    line = {line, text_beat(cfa_pkg::CH_CR, 1'b1, 1'b0)};
            end
        end
        else if (bytes_owed > 0)
        begin
            bytes_owed--;
            if (!frame_discarded)
            begin
                line = {line, text_beat(hex_char(b.data_byte[7:4]), 1'b0, 1'b0)};
                line = {line, text_beat(hex_char(b.data_byte[3:0]), 1'b0, 1'b0)};
                if (bytes_owed == 0)
                    line = {line, text_beat(cfa_pkg::CH_CR, 1'b1, 1'b0)};
            end
        end
        if (line.size() > 0)
            line[line.size() - 1].last = 1'b1;
        expected_text = {expected_text, line};
    endtask

    function automatic cfa_pkg::in_item_t random_item();
        logic [31:0]       w0;
        logic [31:0]       w1;
        cfa_pkg::in_item_t x;
        w0 = $urandom();
        w1 = $urandom();
        x.req_type         = w1[0];
        x.is_fd            = w1[1];
        x.is_remote        = w1[2];
        x.is_extended      = w1[3];
        x.length_code      = w1[7:4];
        x.data_byte        = w1[15:8];
        x.frame_identifier = w0[28:0];
        return x;
    endfunction

    // the beat is predicted when driven: it stays put until taken
    task automatic send_beat(input cfa_pkg::in_item_t b);
        int gap;
        gap = idling ? $urandom_range(0, 19) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item       <= b;
        item_valid <= 1'b1;
        encode_beat(b);
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_header(input logic fd, input logic remote, input logic ext,
                               input logic [28:0] id, input logic [3:0] code);
        cfa_pkg::in_item_t x;
        x = random_item();
        x.req_type         = cfa_pkg::REQ_HEADER;
        x.is_fd            = fd;
        x.is_remote        = remote;
        x.is_extended      = ext;
        x.frame_identifier = id;
        x.length_code      = code;
        send_beat(x);
    endtask

    task automatic send_data_byte(input logic [7:0] v);
        cfa_pkg::in_item_t x;
        x = random_item();
        x.req_type  = cfa_pkg::REQ_DATA;
        x.data_byte = v;
        send_beat(x);
    endtask

    task automatic wait_for_text_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_type_letters();
        send_header(1'b0, 1'b0, 1'b0, 29'h000, 4'd0);
        send_header(1'b0, 1'b0, 1'b1, 29'h1FFFFFFF, 4'd0);
        send_header(1'b0, 1'b1, 1'b0, 29'hFFF, 4'd0);
        send_header(1'b0, 1'b1, 1'b1, 29'h0000000, 4'd0);
        send_header(1'b1, 1'b0, 1'b0, 29'hA5C, 4'd0);
        send_header(1'b1, 1'b0, 1'b1, 29'h15A5A5A5, 4'd0);
        send_header(1'b1, 1'b1, 1'b0, 29'h3D9, 4'd0);
        send_header(1'b1, 1'b1, 1'b1, 29'h0ABCDEF0, 4'd0);
    endtask

    task automatic test_data_bytes();
        send_header(1'b1, 1'b0, 1'b0, 29'hABC, 4'd2);
        send_data_byte(8'h00);
        send_data_byte(8'hFF);
        // remote frames still carry their bytes
        send_header(1'b0, 1'b1, 1'b0, 29'h123, 4'd1);
        send_data_byte(8'h5A);
    endtask

    task automatic test_oversize_identifier();
        send_header(1'b0, 1'b0, 1'b0, 29'h1000, 4'd2);
        send_data_byte(8'hC3);
        send_data_byte(8'h3C);
        send_header(1'b1, 1'b1, 1'b0, 29'h1FFFFFFF, 4'd0);
        send_header(1'b0, 1'b0, 1'b0, 29'hFFF, 4'd0);
    endtask

    task automatic test_header_mid_frame();
        send_header(1'b0, 1'b0, 1'b1, 29'h12345678, 4'd3);
        send_data_byte(8'h3C);
        send_header(1'b0, 1'b0, 1'b0, 29'h007, 4'd0);
    endtask

    task automatic test_extra_bytes();
        send_data_byte(8'h96);
        send_data_byte(8'h69);
    endtask

    task automatic test_full_length_frame();
        logic [31:0] w;
        send_header(1'b1, 1'b0, 1'b1, 29'h1F0E0D0C, 4'd15);
        repeat (byte_count(4'd15))
        begin
            w = $urandom();
            send_data_byte(w[7:0]);
        end
    endtask

    // mostly well-formed frames with random content, some truncated,
    // some with a spare byte, plus stray bytes
    task automatic test_random_traffic(input int target);
        int          sent;
        int          frames;
        int          nbytes;
        int          c;
        logic [31:0] r;
        logic [31:0] w;
        logic [28:0] id;
        logic [3:0]  code;
        sent   = 0;
        frames = 0;
        while (sent < target)
        begin
            r = $urandom();
            w = $urandom();
            idling = (r[1:0] != 2'b00);
            if (r[9:2] < 8'd30)
                send_data_byte(r[31:24]);
            else
            begin
                if (r[10])
                    id = w[28:0];
                else if (r[14:11] == 4'd0)
                    id = w[28:0] | 29'h1000;
                else
                    id = {17'd0, w[11:0]};
                if (r[17:15] < 3'd2)
                    code = {1'b1, r[20:18]};
                else
                begin
                    c    = $urandom_range(0, 8);
                    code = c[3:0];
                end
                nbytes = byte_count(code);
                if (r[23:21] == 3'd0)
                    nbytes = $urandom_range(0, nbytes);
                else if (r[23:21] == 3'd1)
                    nbytes++;
                send_header(w[31], w[30], r[10], id, code);
                repeat (nbytes)
                begin
                    w = $urandom();
                    send_data_byte(w[7:0]);
                end
                sent += 1 + nbytes;
                frames++;
                if (frames % 12 == 0)
                    wait_for_text_drain();
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_text
        cfa_pkg::out_item_t want;
        if (rst_n && text_valid && !text_stall)
        begin
            if (expected_text.size() == 0)
            begin
                $error("text beat %0h with nothing expected", text);
                error_count++;
            end
            else
            begin
                want = expected_text[0];
                expected_text.delete(0);
                check_field("ascii_char", want.ascii_char, text.ascii_char);
                check_field("end_of_line", {7'd0, want.end_of_line}, {7'd0, text.end_of_line});
                check_field("last", {7'd0, want.last}, {7'd0, text.last});
                check_field("frame_dropped", {7'd0, want.frame_dropped},
                            {7'd0, text.frame_dropped});
            end
            rx_wait = idling ? $urandom_range(0, 19) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            text_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end
        else
            text_stall <= 1'b0;
    end

    // counts cycles in which neither side moves a beat
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (text_valid && !text_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idling = 1'b0;
        test_type_letters();
        test_data_bytes();
        test_oversize_identifier();
        test_header_mid_frame();
        test_extra_bytes();

        idling = 1'b1;
        test_full_length_frame();
        wait_for_text_drain();
        test_random_traffic(80);

        wait_for_text_drain();
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_text.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
